// ===== hdl/ogg_page_packet_segmenter_defines.svh =====
// ----------------------------------------------------------------------------
// Ogg page segmenter assertion macros
// Shared property wrappers for the checker of the page segmenter.
// ----------------------------------------------------------------------------
`ifndef OGG_PAGE_PACKET_SEGMENTER_DEFINES_SVH
`define OGG_PAGE_PACKET_SEGMENTER_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is high.
`define OPPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Property checked on every rising edge, reset included.
`define OPPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/opps_pkg.sv =====
// ----------------------------------------------------------------------------
// opps_pkg
// Types and constants shared by the Ogg page segmenter modules.
// ----------------------------------------------------------------------------
package opps_pkg;

  localparam int SEG_LIMIT   = 255;   // lacing entries per page
  localparam int BASE_HDR    = 27;    // fixed page header bytes
  localparam int MAX_RESULTS = 64;    // result records per word
  localparam int LOOP_LIMIT  = MAX_RESULTS - 2;  // placement loop runs below this

  localparam logic [15:0] MAX_FLOOR   = 16'd4096;
  // floor(x / 255) = (x * RECIP_255) >> RECIP_SHIFT, exact for 16-bit x
  localparam logic [15:0] RECIP_255   = 16'd32897;
  localparam int          RECIP_SHIFT = 23;

  localparam int FLAG_CONT = 0;
  localparam int FLAG_BOS  = 1;
  localparam int FLAG_EOS  = 2;
  localparam logic [2:0] FLAGS_BOS = 3'(1 << FLAG_BOS);

  localparam logic [7:0] REG_MIN_PAGE_SIZE  = 8'd0;
  localparam logic [7:0] REG_MAX_PAGE_SIZE  = 8'd1;
  localparam logic [7:0] REG_HEADER_PACKETS = 8'd2;
  localparam logic [7:0] REG_STREAM_SERIAL  = 8'd3;

  typedef enum logic {
    CMD_PACKET = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_kind_t;

  typedef enum logic {
    KIND_PART = 1'b0,
    KIND_PAGE = 1'b1
  } result_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SIZE,
    ST_PLACE,
    ST_CLOSE
  } eng_state_t;

  // Input word data, first field in the low bits.
  typedef struct packed {
    logic [63:0] end_granule;
    logic [15:0] packet_length;
  } in_tdata_t;

  // Output word data, first field in the low bits.
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] page_serial;
    logic [15:0] page_body_bytes;
    logic [7:0]  page_segments;
    logic [63:0] page_granule;
    logic [2:0]  page_flags;
    logic [31:0] page_sequence;
    logic        part_ends_packet;
    logic [15:0] part_length;
    logic [15:0] part_start;
  } out_tdata_t;

  localparam int IN_TDATA_W  = $bits(in_tdata_t);
  localparam int OUT_TDATA_W = $bits(out_tdata_t);

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] len;
    logic [63:0] gran;
  } cmd_t;

  typedef struct packed {
    logic [15:0] min_page_size;
    logic [15:0] max_page_size;
    logic [7:0]  header_packet_count;
    logic [31:0] stream_serial;
  } cfg_t;

  typedef struct packed {
    result_kind_t kind;
    logic [15:0]  part_start;
    logic [15:0]  part_length;
    logic         part_ends_packet;
    logic [31:0]  page_sequence;
    logic [2:0]   page_flags;
    logic [63:0]  page_granule;
    logic [7:0]   page_segments;
    logic [15:0]  page_body_bytes;
    logic [31:0]  page_serial;
    logic         last;
  } result_t;

  function automatic logic [8:0] div255(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'(RECIP_255);
    return prod[RECIP_SHIFT+8:RECIP_SHIFT];
  endfunction

endpackage

// ===== hdl/opps_front.sv =====
// ----------------------------------------------------------------------------
// opps_front
// Input register: takes stream words and decodes them into commands.
// ----------------------------------------------------------------------------
module opps_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [opps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // packet_length, end_granule
  input  logic [0:0]                        s_axis_tuser,  // opcode
  output logic                              push,
  output opps_pkg::cmd_t                    push_data,
  input  logic                              full
);
  import opps_pkg::*;

  in_tdata_t in_word;
  cmd_t      hold;
  logic      hold_valid;

  assign in_word       = s_axis_tdata;
  assign push          = hold_valid;
  assign push_data     = hold;
  assign s_axis_tready = !hold_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_axis_tready) begin
      hold_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hold.kind <= s_axis_tuser[0] ? CMD_FINISH : CMD_PACKET;
      hold.len  <= in_word.packet_length;
      hold.gran <= in_word.end_granule;
    end
  end

endmodule

// ===== hdl/opps_queue.sv =====
// ----------------------------------------------------------------------------
// opps_queue
// Short command queue between the input register and the page engine.
// ----------------------------------------------------------------------------
module opps_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  opps_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output opps_pkg::cmd_t pop_data,
  output logic           empty
);
  import opps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/opps_back.sv =====
// ----------------------------------------------------------------------------
// opps_back
// Page engine: places packet parts on pages and closes pages.
// ----------------------------------------------------------------------------
module opps_back (
  input  logic              clk,
  input  logic              rst,
  input  opps_pkg::cfg_t    cfg,
  input  logic              empty,
  input  opps_pkg::cmd_t    pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output opps_pkg::result_t out_data
);
  import opps_pkg::*;

  localparam int N_W = $clog2(MAX_RESULTS + 1);
  localparam logic [N_W-1:0] N_LIMIT = N_W'(LOOP_LIMIT);
  localparam logic [16:0]    PB_BASE = 17'(BASE_HDR);
  localparam logic [7:0]     SEG_TOP = 8'(SEG_LIMIT - 1);

  eng_state_t state;
  eng_state_t state_next;

  // open page
  logic [16:0] page_bytes;
  logic [7:0]  seg_count;
  logic        has_data;
  logic [31:0] open_seq;
  logic [31:0] next_seq;
  logic [2:0]  open_flags;
  logic [63:0] open_gran;
  logic [7:0]  packets_seen;

  // packet in progress
  logic [63:0]    pkt_gran;
  logic [15:0]    remaining;
  logic [15:0]    start;
  logic [N_W-1:0] n_out;
  logic           tail_close;
  logic [7:0]     seg_q;
  logic [8:0]     lim_q;
  logic [7:0]     rem_q;
  logic [15:0]    take;
  logic [7:0]     take_q;
  logic           ends;

  logic           out_free;
  logic [15:0]    max_eff;
  logic [16:0]    max_gap;
  logic [15:0]    lim_room;
  logic [7:0]     seg_q_calc;
  logic           loop_end;
  logic           hdr_open;
  logic           hdr_close;
  logic [8:0]     space_q;
  logic [16:0]    space;
  logic           space_short;
  logic           break_now;
  logic [7:0]     segs;
  logic [16:0]    pb_new;
  logic           close_now;
  logic [15:0]    rem_new;
  logic [N_W-1:0] n_part;
  logic           part_last;
  logic           close_last;
  logic [15:0]    body;
  result_t        part_res;
  result_t        page_res;

  logic calc_step;
  logic calc_tail;
  logic do_break;
  logic do_place;
  logic emit_part;
  logic emit_page;

  // Room and placement arithmetic.
  always_comb begin
    out_free   = !out_valid || out_ready;
    max_eff    = (cfg.max_page_size < MAX_FLOOR) ? MAX_FLOOR : cfg.max_page_size;
    max_gap    = {1'b0, max_eff} - page_bytes;
    lim_room   = ({1'b0, max_eff} > page_bytes) ? max_gap[15:0] : '0;
    seg_q_calc = (seg_count >= SEG_TOP) ? '0 : SEG_TOP - seg_count;
    loop_end   = (remaining == '0) || (n_out >= N_LIMIT);
    hdr_open   = (packets_seen < cfg.header_packet_count);
    hdr_close  = hdr_open && has_data;

    space_q     = ({1'b0, seg_q} < lim_q) ? {1'b0, seg_q} : lim_q;
    space       = {space_q, 8'h00} - {8'h00, space_q};
    space_short = (space < {1'b0, remaining});

    break_now  = (take == '0) && (seg_count == '0) && (page_bytes == PB_BASE);
    segs       = take_q + {7'b0, ends};
    pb_new     = page_bytes + {9'b0, segs} + {1'b0, take};
    close_now  = (pb_new >= {1'b0, cfg.min_page_size}) || (open_seq == '0) ||
                 (take == '0);
    rem_new    = remaining - take;
    n_part     = n_out + N_W'(take != '0);
    part_last  = !close_now && ((rem_new == '0) || (n_part >= N_LIMIT)) && !hdr_open;
    close_last = tail_close || (remaining == '0) || ((n_out + 1'b1) >= N_LIMIT);
    body       = 16'(page_bytes - PB_BASE - {9'b0, seg_count});
  end

  always_comb begin
    part_res                  = '0;
    part_res.kind             = KIND_PART;
    part_res.part_start       = start;
    part_res.part_length      = take;
    part_res.part_ends_packet = ends;
    part_res.page_sequence    = open_seq;
    part_res.last             = part_last;

    page_res                 = '0;
    page_res.kind            = KIND_PAGE;
    page_res.page_sequence   = open_seq;
    page_res.page_flags      = open_flags;
    page_res.page_granule    = open_gran;
    page_res.page_segments   = seg_count;
    page_res.page_body_bytes = body;
    page_res.page_serial     = cfg.stream_serial;
    page_res.last            = close_last;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          state_next = (pop_data.kind == CMD_FINISH) ? ST_CLOSE : ST_CALC;
        end
      end
      ST_CALC: begin
        if (loop_end) begin
          state_next = hdr_close ? ST_CLOSE : ST_IDLE;
        end else begin
          state_next = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_next = ST_PLACE;
      end
      ST_PLACE: begin
        if (break_now) begin
          state_next = ST_CALC;
        end else if (out_free) begin
          state_next = close_now ? ST_CLOSE : ST_CALC;
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          state_next = tail_close ? ST_IDLE : ST_CALC;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    pop       = 1'b0;
    calc_step = 1'b0;
    calc_tail = 1'b0;
    do_break  = 1'b0;
    do_place  = 1'b0;
    emit_page = 1'b0;
    case (state)
      ST_IDLE: begin
        pop = !empty;
      end
      ST_CALC: begin
        calc_step = !loop_end;
        calc_tail = loop_end;
      end
      ST_PLACE: begin
        do_break = break_now;
        do_place = !break_now && out_free;
      end
      ST_CLOSE: begin
        emit_page = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    emit_part = do_place && (take != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      page_bytes   <= PB_BASE;
      seg_count    <= '0;
      has_data     <= 1'b0;
      open_seq     <= '0;
      next_seq     <= 32'd1;
      open_flags   <= FLAGS_BOS;
      open_gran    <= '1;
      packets_seen <= '0;
    end else begin
      state <= state_next;
      if (emit_part || emit_page) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (pop_data.kind == CMD_FINISH) begin
          open_flags[FLAG_EOS] <= 1'b1;
        end else begin
          has_data <= 1'b1;
        end
      end
      if (calc_tail && (packets_seen != 8'hFF)) begin
        packets_seen <= packets_seen + 1'b1;
      end
      if (do_place) begin
        if (!has_data && (start != '0)) begin
          open_flags[FLAG_CONT] <= 1'b1;
        end
        if (take != '0) begin
          seg_count  <= seg_count + segs;
          page_bytes <= pb_new;
          has_data   <= 1'b1;
          if (ends) begin
            open_gran <= pkt_gran;
          end
        end
      end
      if (emit_page) begin
        // open a fresh page
        open_seq   <= next_seq;
        open_flags <= (next_seq == '0) ? FLAGS_BOS : '0;
        open_gran  <= '1;
        next_seq   <= next_seq + 1'b1;
        page_bytes <= PB_BASE;
        seg_count  <= '0;
        has_data   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      n_out      <= '0;
      pkt_gran   <= pop_data.gran;
      start      <= '0;
      remaining  <= (pop_data.kind == CMD_FINISH) ? '0 : pop_data.len;
      tail_close <= (pop_data.kind == CMD_FINISH);
    end
    if (calc_step) begin
      seg_q <= seg_q_calc;
      lim_q <= div255(lim_room);
      rem_q <= 8'(div255(remaining));
    end
    if (calc_tail && hdr_close) begin
      tail_close <= 1'b1;
    end
    if (state == ST_SIZE) begin
      take   <= space_short ? space[15:0] : remaining;
      take_q <= space_short ? space_q[7:0] : rem_q;
      ends   <= !space_short;
    end
    if (do_break) begin
      remaining <= '0;
    end
    if (do_place) begin
      start     <= start + take;
      remaining <= rem_new;
      n_out     <= n_part;
    end
    if (emit_page) begin
      n_out <= n_out + 1'b1;
    end
    if (emit_part) begin
      out_data <= part_res;
    end else if (emit_page) begin
      out_data <= page_res;
    end
  end

endmodule

// ===== hdl/ogg_page_packet_segmenter.sv =====
// ----------------------------------------------------------------------------
// ogg_page_packet_segmenter
// Cuts packet descriptors into Ogg page parts and page records.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Word                                  Accepted when
//  s_axis   in   packet descriptor or finish command   s_axis_tvalid & s_axis_tready
//  m_axis   out  part record or page record            m_axis_tvalid & m_axis_tready
//  cfg      in   register write (index, data)          cfg_valid & cfg_ready
//
//  Steps: a finish is dequeued, then its page record is sent. A packet is
//  dequeued, then each placement attempt runs room calc with the divide-by-255
//  multiply, sizing and placement, each closed page adds a page record step,
//  and a last room calc ends the packet. The page engine loop sets this order.
//  Reset: synchronous; page state returns to page zero, config to defaults.
//  Stalls: m_axis back pressure holds the engine only; the input register and
//  the command queue keep taking words until QUEUE_DEPTH + 1 are held.
//
module ogg_page_packet_segmenter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [opps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // packet_length, end_granule
  input  logic [0:0]                       s_axis_tuser,  // opcode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // part_start, part_length, part_ends_packet, page_sequence, page_flags,
  // page_granule, page_segments, page_body_bytes, page_serial, zero pad
  output logic [opps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]                       m_axis_tuser,  // result_kind
  output logic                             m_axis_tlast,  // last_of_run
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [7:0]                       cfg_index,
  input  logic [31:0]                      cfg_data
);
  import opps_pkg::*;

  cfg_t       cfg;
  cmd_t       push_data;
  cmd_t       pop_data;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  result_t    res;
  logic       res_valid;
  out_tdata_t out_word;

  // Config writes are registered; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_page_size       <= 16'd4096;
      cfg.max_page_size       <= 16'd8192;
      cfg.header_packet_count <= 8'd3;
      cfg.stream_serial       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_PAGE_SIZE:  cfg.min_page_size       <= cfg_data[15:0];
        REG_MAX_PAGE_SIZE:  cfg.max_page_size       <= cfg_data[15:0];
        REG_HEADER_PACKETS: cfg.header_packet_count <= cfg_data[7:0];
        REG_STREAM_SERIAL:  cfg.stream_serial       <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // Front: register and decode incoming words.
  opps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  // Queue: lets the front keep accepting while the engine waits on m_axis.
  opps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Back: page engine with its own output register.
  opps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (res_valid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  // Pack the result record onto the output word.
  always_comb begin
    out_word                  = '0;
    out_word.part_start       = res.part_start;
    out_word.part_length      = res.part_length;
    out_word.part_ends_packet = res.part_ends_packet;
    out_word.page_sequence    = res.page_sequence;
    out_word.page_flags       = res.page_flags;
    out_word.page_granule     = res.page_granule;
    out_word.page_segments    = res.page_segments;
    out_word.page_body_bytes  = res.page_body_bytes;
    out_word.page_serial      = res.page_serial;
  end

  assign m_axis_tvalid   = res_valid;
  assign m_axis_tdata    = out_word;
  assign m_axis_tuser[0] = res.kind;
  assign m_axis_tlast    = res.last;

endmodule

// ===== hdl/opps_checker.sv =====
// ----------------------------------------------------------------------------
// opps_checker
// Port-level checks on the page segmenter output, bound to the top level.
// ----------------------------------------------------------------------------
`include "ogg_page_packet_segmenter_defines.svh"

module opps_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [opps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                       m_axis_tuser,
  input logic                             m_axis_tlast
);
  import opps_pkg::*;

  out_tdata_t             word;
  logic [OUT_TDATA_W+1:0] out_bus;
  logic [OUT_TDATA_W+1:0] out_bus_q;
  logic                   stall;
  logic                   held;
  logic                   eos_page;
  logic                   part_seen;
  logic                   part_clean;

  // Keep the previous output word to compare against under a stall.
  always_ff @(posedge clk) begin
    out_bus_q <= out_bus;
  end

  assign word       = m_axis_tdata;
  assign out_bus    = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign held       = m_axis_tvalid && (out_bus == out_bus_q);
  assign eos_page   = m_axis_tvalid && (m_axis_tuser[0] == KIND_PAGE) &&
                      word.page_flags[FLAG_EOS];
  assign part_seen  = m_axis_tvalid && (m_axis_tuser[0] == KIND_PART);
  assign part_clean = (word.part_length != '0) && (word.page_flags == '0) &&
                      (word.page_segments == '0) && (word.page_serial == '0);

  `OPPS_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_axis_tvalid, "output valid after reset")
  `OPPS_ASSERT(a_stall_holds, clk, rst, stall |=> held, "output word changed under stall")
  `OPPS_ASSERT(a_eos_is_last, clk, rst, eos_page |-> m_axis_tlast, "EOS page not last of run")
  `OPPS_ASSERT(a_part_fields, clk, rst, part_seen |-> part_clean, "malformed part record")

endmodule

bind ogg_page_packet_segmenter opps_checker u_opps_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Ogg page segmenter. Stream packet descriptors
// and finish commands into s_axis, predict every part and page record in a
// local page model, and compare each m_axis word field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import opps_pkg::*;

  localparam int LACE_BYTES   = 255;      // bytes per full lacing value
  localparam int DRAIN_CYCLES = 200;      // covers the longest packet in the engine
  localparam int CYCLE_LIMIT  = 600000;   // generous cap on the whole run
  localparam int HOLD_CYCLES  = 300;      // long m_axis hold-off

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // packet_length, end_granule
  logic [0:0]             s_axis_tuser = '0;   // opcode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // part_start, part_length, part_ends_packet, page_sequence, page_flags,
  // page_granule, page_segments, page_body_bytes, page_serial, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;        // result_kind
  logic                   m_axis_tlast;        // last_of_run
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [7:0]             cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  ogg_page_packet_segmenter u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Page model: a local copy of the open page and of the registers
  // --------------------------------------------------------------------------
  int unsigned page_size_now;     // header + lacing + body bytes of the open page
  int unsigned lacing_used;       // segment table entries on the open page
  bit          page_marked;       // open page holds data (or a packet arrived)
  logic [31:0] page_seq_now;
  logic [31:0] page_seq_next;
  logic [2:0]  page_flags_now;
  logic [63:0] page_granule_now;
  int unsigned packets_counted;   // saturates at 255

  int unsigned min_size_reg;
  int unsigned max_size_reg;
  int unsigned header_pkts_reg;
  logic [31:0] serial_reg;

  result_t word_records[$];       // records caused by the word being predicted
  result_t expected_records[$];   // records still owed by the block

  // Run bookkeeping
  int mismatch_count = 0;
  int words_sent     = 0;
  int finishes_sent  = 0;
  int parts_checked  = 0;
  int pages_checked  = 0;
  int settings_used  = 1;         // reset values count as the first setting
  int cycle_count    = 0;

  // Idle control for both sides
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  function automatic void push_record(input result_t rec);
    if (word_records.size() < MAX_RESULTS) word_records.push_back(rec);
  endfunction

  function automatic void open_fresh_page();
    page_seq_now     = page_seq_next;
    page_flags_now   = (page_seq_next == 32'd0) ? FLAGS_BOS : 3'b000;
    page_granule_now = '1;
    page_seq_next    = page_seq_next + 32'd1;
    page_size_now    = BASE_HDR;
    lacing_used      = 0;
    page_marked      = 1'b0;
  endfunction

  function automatic void model_reset();
    min_size_reg    = 4096;
    max_size_reg    = 8192;
    header_pkts_reg = 3;
    serial_reg      = '0;
    packets_counted = 0;
    page_seq_next   = '0;
    open_fresh_page();
  endfunction

  // Emit the page record of the open page, then start the next page.
  function automatic void close_open_page();
    result_t rec;
    rec                 = '0;
    rec.kind            = KIND_PAGE;
    rec.page_sequence   = page_seq_now;
    rec.page_flags      = page_flags_now;
    rec.page_granule    = page_granule_now;
    rec.page_segments   = 8'(lacing_used);
    rec.page_body_bytes = 16'(page_size_now - BASE_HDR - lacing_used);
    rec.page_serial     = serial_reg;
    push_record(rec);
    open_fresh_page();
  endfunction

  // Cut one packet into parts over as many pages as it needs.
  function automatic void place_packet(input logic [15:0] len, input logic [63:0] gran);
    int unsigned offset, left, max_eff, seg_room, lim_room, space, take, segs;
    bit          ends;
    result_t     rec;
    offset  = 0;
    left    = len;
    max_eff = (max_size_reg < MAX_FLOOR) ? MAX_FLOOR : max_size_reg;
    page_marked = 1'b1;
    while (left > 0 && word_records.size() + 3 <= MAX_RESULTS) begin
      seg_room = (lacing_used >= SEG_LIMIT) ? 0 : (SEG_LIMIT - lacing_used) * LACE_BYTES - 1;
      lim_room = (max_eff > page_size_now) ? max_eff - page_size_now : 0;
      space    = (seg_room < lim_room) ? seg_room : lim_room;
      space    = space - space % LACE_BYTES;
      take     = (space < left) ? space : left;
      // nothing fits even on an empty page: drop the rest of the packet
      if (take == 0 && lacing_used == 0 && page_size_now == BASE_HDR) break;
      if (!page_marked && offset != 0) page_flags_now[FLAG_CONT] = 1'b1;
      if (take > 0) begin
        ends          = (offset + take == len);
        segs          = take / LACE_BYTES + (ends ? 1 : 0);
        lacing_used   = lacing_used + segs;
        page_size_now = page_size_now + segs + take;
        page_marked   = 1'b1;
        if (ends) page_granule_now = gran;
        rec                  = '0;
        rec.kind             = KIND_PART;
        rec.part_start       = 16'(offset);
        rec.part_length      = 16'(take);
        rec.part_ends_packet = ends;
        rec.page_sequence    = page_seq_now;
        push_record(rec);
      end
      if (page_size_now >= min_size_reg || page_seq_now == 32'd0 || take == 0)
        close_open_page();
      offset = offset + take;
      left   = left - take;
    end
    // header packets each end their own page
    if (packets_counted < header_pkts_reg && page_marked) close_open_page();
    if (packets_counted < 255) packets_counted++;
  endfunction

  // Work out every record that one accepted word causes and queue them.
  function automatic void predict_word(input cmd_kind_t op, input logic [15:0] len,
                                       input logic [63:0] gran);
    result_t rec;
    word_records.delete();
    if (op == CMD_FINISH) begin
      page_flags_now[FLAG_EOS] = 1'b1;
      close_open_page();
    end else begin
      place_packet(len, gran);
    end
    if (word_records.size() > 0) begin
      rec      = word_records.pop_back();
      rec.last = 1'b1;
      word_records.push_back(rec);
    end
    foreach (word_records[i]) expected_records.push_back(word_records[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side: stream words and register writes
  // --------------------------------------------------------------------------
  // Offer one word, hold it until taken, then predict its records.
  task automatic send_word(input cmd_kind_t op, input logic [15:0] len,
                           input logic [63:0] gran);
    in_tdata_t word;
    word.packet_length = len;
    word.end_granule   = gran;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (op == CMD_FINISH) finishes_sent++;
    predict_word(op, len, gran);
  endtask

  task automatic send_packet(input logic [15:0] len, input logic [63:0] gran);
    send_word(CMD_PACKET, len, gran);
  endtask

  // Finish carries random data fields, which the block must ignore.
  task automatic send_finish();
    send_word(CMD_FINISH, 16'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_random_word();
    int          pick;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_finish();
    end else begin
      if (pick < 40)      len = 16'($urandom_range(0, 300));
      else if (pick < 55) len = 16'(LACE_BYTES * $urandom_range(1, 20) + $urandom_range(0, 2) - 1);
      else if (pick < 88) len = 16'($urandom_range(0, 9000));
      else                len = 16'($urandom_range(0, 65535));
      send_packet(len, {$urandom, $urandom});
    end
  endtask

  // Drop valid and wait until every owed record is out.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  // Drain, then give words that cause no record time to leave the engine.
  task automatic settle();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_PAGE_SIZE:  min_size_reg    = val[15:0];
      REG_MAX_PAGE_SIZE:  max_size_reg    = val[15:0];
      REG_HEADER_PACKETS: header_pkts_reg = val[7:0];
      REG_STREAM_SERIAL:  serial_reg      = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned min_size, input int unsigned max_size,
                               input int unsigned hdr_pkts, input logic [31:0] serial);
    settle();
    write_reg(REG_MIN_PAGE_SIZE, min_size);
    write_reg(REG_MAX_PAGE_SIZE, max_size);
    write_reg(REG_HEADER_PACKETS, hdr_pkts);
    write_reg(REG_STREAM_SERIAL, serial);
    settings_used++;
  endtask

  // Random setting with a fair share of the extremes.
  task automatic apply_random_setting();
    int unsigned min_size, max_size;
    case ($urandom_range(0, 3))
      0:       min_size = 0;
      1:       min_size = 65307;
      default: min_size = $urandom_range(0, 16384);
    endcase
    case ($urandom_range(0, 4))
      0:       max_size = 4096;
      1:       max_size = 65307;
      2:       max_size = $urandom_range(0, 4095);   // below the floor
      default: max_size = $urandom_range(4096, 20000);
    endcase
    apply_setting(min_size, max_size, $urandom_range(0, 255), $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stall bursts plus one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 4);   // random stall burst length
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Record checker: every taken m_axis word against the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : record_check
    out_tdata_t got;
    result_t    want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = out_tdata_t'(m_axis_tdata);
      if (expected_records.size() == 0) begin
        $error("unexpected record word: kind %0d, sequence %0d", m_axis_tuser, got.page_sequence);
        mismatch_count++;
      end else begin
        want = expected_records.pop_front();
        if (want.kind == KIND_PAGE) pages_checked++;
        else                        parts_checked++;
        check_field("result_kind",      want.kind,             m_axis_tuser);
        check_field("part_start",       want.part_start,       got.part_start);
        check_field("part_length",      want.part_length,      got.part_length);
        check_field("part_ends_packet", want.part_ends_packet, got.part_ends_packet);
        check_field("page_sequence",    want.page_sequence,    got.page_sequence);
        check_field("page_flags",       want.page_flags,       got.page_flags);
        check_field("page_granule",     want.page_granule,     got.page_granule);
        check_field("page_segments",    want.page_segments,    got.page_segments);
        check_field("page_body_bytes",  want.page_body_bytes,  got.page_body_bytes);
        check_field("page_serial",      want.page_serial,      got.page_serial);
        check_field("last_of_run",      want.last,             m_axis_tlast);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records still owed",
               cycle_count, expected_records.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset setting: page zero, header pages (one of them empty from a
  // zero-length packet), a packet that continues over pages, lacing edges
  // around 255 and two finishes, the second on an empty page.
  task automatic test_header_pages();
    send_packet(16'd1,     64'd0);
    send_packet(16'd0,     64'hFFFF_FFFF_FFFF_FFFF);
    send_packet(16'd255,   64'h7FFF_FFFF_FFFF_FFFF);
    send_packet(16'd65535, 64'h8000_0000_0000_0000);
    send_packet(16'd254,   64'h0123_4567_89AB_CDEF);
    send_packet(16'd256,   64'hFEDC_BA98_7654_3210);
    send_packet(16'd510,   64'd42);
    send_finish();
    send_finish();
  endtask

  // Register extremes: close on every part, the segment table limit,
  // a max size below the floor and the largest pages.
  task automatic test_page_limits();
    apply_setting(0, 65307, 255, 32'hFFFF_FFFF);
    send_packet(16'd65535, 64'd1000);
    send_packet(16'd0,     64'd1001);   // empty header page
    send_packet(16'd1000,  64'd1002);
    apply_setting(65307, 1000, 0, 32'h5A5A_A5A5);
    send_packet(16'd65535, 64'd2000);
    send_packet(16'd4000,  64'd2001);
    send_packet(16'd300,   64'd2002);
    send_finish();
    apply_setting(65307, 65307, 0, 32'h0000_0001);
    send_packet(16'd65535, 64'd3000);
    send_packet(16'd65535, 64'd3001);
    send_packet(16'd100,   64'd3002);
    send_finish();
  endtask

  // Hold m_axis off for a long stretch while words keep coming, so the queue
  // fills and s_axis stalls; then pause the sender until all records are out.
  task automatic test_backpressure();
    apply_setting(0, 4096, 0, $urandom);
    hold_left <= HOLD_CYCLES;
    repeat (15) send_random_word();
    wait_for_drain();
    repeat (10) send_random_word();
  endtask

  task automatic test_random_traffic();
    repeat (4) begin
      apply_random_setting();
      repeat (30) send_random_word();
    end
  endtask

  // Last stretch with both sides at full rate.
  task automatic test_quiet_tail();
    apply_random_setting();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    repeat (20) send_random_word();
  endtask

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_pages();
    test_page_limits();
    test_backpressure();
    test_random_traffic();
    test_quiet_tail();
    settle();
    $display("Sent %0d words (%0d finish) under %0d register settings",
             words_sent, finishes_sent, settings_used);
    $display("Checked %0d part records and %0d page records", parts_checked, pages_checked);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/opps_pkg.sv
hdl/opps_front.sv
hdl/opps_queue.sv
hdl/opps_back.sv
hdl/ogg_page_packet_segmenter.sv
hdl/opps_checker.sv
bench/tb_top.sv
